[hdl/ntis_pkg.sv]
// ----------------------------------------------------------------------------
// ntis_pkg
// Types, codes and sizes shared by the name table blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ntis_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = 5;
   localparam int KEY_W    = 64;

   localparam logic [1:0] ACT_CREATE = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;
   localparam logic [1:0] ACT_LIST   = 2'd3;

   localparam logic [2:0] STAT_CREATED  = 3'd0;
   localparam logic [2:0] STAT_EXISTS   = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_DELETED  = 3'd3;
   localparam logic [2:0] STAT_NOTFOUND = 3'd4;
   localparam logic [2:0] STAT_FOUND    = 3'd5;
   localparam logic [2:0] STAT_EMPTY    = 3'd6;
   localparam logic [2:0] STAT_LISTED   = 3'd7;

   typedef struct packed {
      logic [1:0]       action;
      logic [KEY_W-1:0] name_key;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [KEY_W-1:0]   entry_key;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DEL_RD,
      S_DEL_WR,
      S_EMIT,
      S_LIST_RD,
      S_LIST_OUT
   } state_type;

endpackage

`default_nettype wire

[hdl/name_table_insert_delete_search.sv]
// ----------------------------------------------------------------------------
// name_table_insert_delete_search
// Single-level name directory: create, delete, search and list of unique
// 64-bit name keys held in a small RAM.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY unique keys in slots 0 to count-1 of a
// RAM with registered read data. One command is worked at a time. Create,
// search and delete scan the stored keys one per cycle until a hit or the
// last stored key; delete then reads the last entry and writes it into the
// freed slot. List reads the first stored key, then gives one beat per stored
// key per cycle while the result side keeps up; an empty table gives one
// "empty" beat. A new command is taken as soon as the sequencer is idle, even
// while the final result beat still waits in the output register. No clearing
// pass is needed after reset: only slots below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module name_table_insert_delete_search import ntis_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req_data,
   output logic         req_stall,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    rsp_stall
);

   // output register parting the sequencer from the result side
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    out_free;

   emit_type           emit;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [KEY_W-1:0]   wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [KEY_W-1:0]   rd_data;

   // the key store; the sequencer's states keep reads and writes apart
   ntis_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ntis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .out_free  (out_free),
      .emit      (emit),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // the register can take a beat when empty or when its beat leaves now
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[hdl/ntis_ram.sv]
// ----------------------------------------------------------------------------
// ntis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/ntis_ctrl.sv]
// ----------------------------------------------------------------------------
// ntis_ctrl
// Sequencer: scans the key RAM, resolves each command, writes back and
// issues result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_ctrl import ntis_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire req_type            req_data,
   output logic                    req_stall,
   input  wire logic               out_free,
   output emit_type                emit,
   output logic                    wr_en,
   output logic [ADDR_W-1:0]       wr_addr,
   output logic [KEY_W-1:0]        wr_data,
   output logic                    rd_en,
   output logic [ADDR_W-1:0]       rd_addr,
   input  wire logic [KEY_W-1:0]   rd_data
);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [1:0]         act_ff, act_in;
   logic [COUNT_W-1:0] issue_ff, issue_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic [2:0]         status_ff, status_in;
   logic               inc_ff, inc_in;
   logic               dec_ff, dec_in;

   logic               hit;
   logic               more;
   logic [COUNT_W-1:0] count_nx;
   logic [COUNT_W-1:0] count_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      key_ff     <= key_in;
      act_ff     <= act_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      slot_ff    <= slot_in;
      status_ff  <= status_in;
      inc_ff     <= inc_in;
      dec_ff     <= dec_in;
   end

   assign count_m1 = count_ff - COUNT_W'(1);
   assign count_nx = count_ff + COUNT_W'(inc_ff) - COUNT_W'(dec_ff);
   assign hit      = cmp_vld_ff && (rd_data == key_ff);
   assign more     = issue_ff < count_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      act_in     = act_ff;
      issue_in   = issue_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      slot_in    = slot_ff;
      status_in  = status_ff;
      inc_in     = inc_ff;
      dec_in     = dec_ff;
      req_stall  = (state_ff != S_IDLE);
      emit       = '0;
      wr_en      = 1'b0;
      wr_addr    = slot_ff;
      wr_data    = rd_data;
      rd_en      = 1'b0;
      rd_addr    = issue_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_data.name_key;
               act_in   = req_data.action;
               issue_in = '0;
               inc_in   = 1'b0;
               dec_in   = 1'b0;
               if (req_data.action == ACT_LIST) begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = S_EMIT;
                  end else begin
                     state_in  = S_LIST_RD;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // stream reads, compare each one when its data returns from the RAM
            rd_en      = !hit && more;
            cmp_vld_in = rd_en;
            cmp_idx_in = issue_ff[ADDR_W-1:0];
            if (rd_en) begin
               issue_in = issue_ff + COUNT_W'(1);
            end
            if (hit) begin
               case (act_ff)
                  ACT_CREATE: begin
                     status_in = STAT_EXISTS;
                     state_in  = S_EMIT;
                  end
                  ACT_DELETE: begin
                     slot_in  = cmp_idx_ff;
                     state_in = S_DEL_RD;
                  end
                  default: begin
                     status_in = STAT_FOUND;
                     state_in  = S_EMIT;
                  end
               endcase
            end else if (!more) begin
               if (act_ff == ACT_CREATE) begin
                  if (count_ff >= COUNT_W'(CAPACITY)) begin
                     status_in = STAT_FULL;
                  end else begin
                     status_in = STAT_CREATED;
                     inc_in    = 1'b1;
                  end
               end else begin
                  status_in = STAT_NOTFOUND;
               end
               state_in = S_EMIT;
            end
         end
         S_DEL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = count_m1[ADDR_W-1:0];
            state_in = S_DEL_WR;
         end
         S_DEL_WR: begin
            // move the last entry into the freed slot
            wr_en     = 1'b1;
            wr_addr   = slot_ff;
            wr_data   = rd_data;
            status_in = STAT_DELETED;
            dec_in    = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               wr_en                  = inc_ff;
               wr_addr                = count_ff[ADDR_W-1:0];
               wr_data                = key_ff;
               count_in               = count_nx;
               emit.valid             = 1'b1;
               emit.data.status       = status_ff;
               emit.data.entry_key    = '0;
               emit.data.entry_count  = count_nx;
               emit.data.last         = 1'b1;
               state_in               = S_IDLE;
            end
         end
         S_LIST_RD: begin
            rd_en    = 1'b1;
            state_in = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            if (out_free) begin
               emit.valid            = 1'b1;
               emit.data.status      = STAT_LISTED;
               emit.data.entry_key   = rd_data;
               emit.data.entry_count = count_ff;
               emit.data.last        = (issue_ff == count_m1);
               if (issue_ff == count_m1) begin
                  state_in = S_IDLE;
               end else begin
                  // fetch the next entry while this beat leaves
                  rd_en    = 1'b1;
                  rd_addr  = issue_ff[ADDR_W-1:0] + ADDR_W'(1);
                  issue_in = issue_ff + COUNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("RAM read and write in the same cycle");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("result beat issued into a full output register");

   a_only_list_continues: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && !emit.data.last) |-> (emit.data.status == STAT_LISTED))
      else $error("non-final beat that is not a listed entry");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("sequencer idle after accepting a command");
`endif

endmodule

`default_nettype wire
